// File: rtl/vtp_pkg.sv
package vtp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } vtp_req_t;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [63:0] field_value;
        logic [31:0] item_index;
        logic [2:0]  status;
    } vtp_rsp_t;

    // field_kind codes
    localparam logic [3:0] KIND_NONE       = 4'd0;
    localparam logic [3:0] KIND_VERSION    = 4'd1;
    localparam logic [3:0] KIND_IN_COUNT   = 4'd2;
    localparam logic [3:0] KIND_ID_BYTE    = 4'd3;
    localparam logic [3:0] KIND_INDEX      = 4'd4;
    localparam logic [3:0] KIND_IN_SLEN    = 4'd5;
    localparam logic [3:0] KIND_IN_SCRIPT  = 4'd6;
    localparam logic [3:0] KIND_SEQUENCE   = 4'd7;
    localparam logic [3:0] KIND_OUT_COUNT  = 4'd8;
    localparam logic [3:0] KIND_AMOUNT     = 4'd9;
    localparam logic [3:0] KIND_OUT_SLEN   = 4'd10;
    localparam logic [3:0] KIND_OUT_SCRIPT = 4'd11;
    localparam logic [3:0] KIND_LOCK_TIME  = 4'd12;

    // status codes
    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_TRAILING  = 3'd3;
    localparam logic [2:0] ST_OVERSIZE  = 3'd4;

    // varint prefixes
    localparam logic [7:0] VARINT_16 = 8'hfd;
    localparam logic [7:0] VARINT_32 = 8'hfe;

    localparam int ID_BYTES = 32;

    // handshake controls between stages
    typedef struct packed {
        logic valid;
        logic advance;
    } vtp_stage_ctl_t;

endpackage

// File: rtl/varint_transaction_parser_core.sv
// Byte-serial parser for serialized transactions with varint counts.
// Input channel s_valid/s_ready/s_req: one transaction byte per request,
// in_last set on the final byte of the buffer.
// Result channel m_valid/m_ready/m_rsp: exactly one result per byte, in
// order: completed field kind and value (or payload byte), item index and
// status. The last byte carries the final status; the parser then rearms
// for the next transaction.
// A request goes through the input register, then the result register,
// on its way to m_valid.
// Throughput: one byte per cycle while m_ready is high; the per-byte field
// decode is one short step between the input register and the result register.
// Reset (aresetn, synchronous, active low) empties both registers and
// returns the parser to the version field.
// When m_ready is low the result register holds; one more request can wait
// in the input register, after which s_ready drops.
// COUNT_BITS bounds counts and script lengths to 2^min(COUNT_BITS,32)-1.
module varint_transaction_parser_core
    import vtp_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  vtp_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output vtp_rsp_t m_rsp
);

    vtp_stage_ctl_t ctl;
    vtp_req_t       req_data;
    vtp_rsp_t       rsp;
    logic           req_valid;
    logic           out_free;
    logic           step;

    assign step = req_valid && out_free;
    assign ctl  = '{valid: req_valid, advance: out_free};

    vtp_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .advance   (step),
        .req_valid (req_valid),
        .req_data  (req_data)
    );

    vtp_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .req     (req_data),
        .rsp     (rsp)
    );

    vtp_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .rsp     (rsp),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("decoded request did not reach result register");

    a_ok_on_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status == ST_OK) |-> (m_rsp.field_kind == KIND_LOCK_TIME))
        else $error("complete status without lock time");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.field_kind == KIND_NONE) |-> (m_rsp.field_value == 64'd0))
        else $error("mid-field result with nonzero value");

    a_global_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_rsp.field_kind == KIND_VERSION || m_rsp.field_kind == KIND_IN_COUNT
            || m_rsp.field_kind == KIND_OUT_COUNT || m_rsp.field_kind == KIND_LOCK_TIME))
        |-> (m_rsp.item_index == 32'd0))
        else $error("nonzero item index on transaction-level field");

endmodule

// File: rtl/vtp_in_stage.sv
module vtp_in_stage
    import vtp_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  vtp_req_t       s_req,
    input  logic           advance,
    output logic           req_valid,
    output vtp_req_t       req_data
);

    logic     valid_reg;
    logic     valid_next;
    vtp_req_t data_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_req;
        end
    end

    assign req_valid = valid_reg;
    assign req_data  = data_reg;

endmodule

// File: rtl/vtp_decode.sv
module vtp_decode
    import vtp_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  vtp_stage_ctl_t ctl,
    input  vtp_req_t       req,
    output vtp_rsp_t       rsp
);

    localparam int CNT_W = (COUNT_BITS >= 32) ? 32 : COUNT_BITS;

    localparam logic [3:0] PH_VERSION    = 4'd0;
    localparam logic [3:0] PH_IN_COUNT   = 4'd1;
    localparam logic [3:0] PH_IN_ID      = 4'd2;
    localparam logic [3:0] PH_IN_INDEX   = 4'd3;
    localparam logic [3:0] PH_IN_SLEN    = 4'd4;
    localparam logic [3:0] PH_IN_SCRIPT  = 4'd5;
    localparam logic [3:0] PH_IN_SEQ     = 4'd6;
    localparam logic [3:0] PH_OUT_COUNT  = 4'd7;
    localparam logic [3:0] PH_OUT_AMOUNT = 4'd8;
    localparam logic [3:0] PH_OUT_SLEN   = 4'd9;
    localparam logic [3:0] PH_OUT_SCRIPT = 4'd10;
    localparam logic [3:0] PH_LOCK       = 4'd11;
    localparam logic [3:0] PH_DRAIN      = 4'd12;

    logic [3:0]       phase_reg, phase_next;
    logic [3:0]       bif_reg, bif_next;
    logic [63:0]      shift_reg, shift_next;
    logic [3:0]       vwidth_reg, vwidth_next;
    logic [CNT_W-1:0] items_reg, items_next;
    logic [CNT_W-1:0] counter_reg, counter_next;
    logic [CNT_W-1:0] script_reg, script_next;
    logic [2:0]       err_reg, err_next;

    logic [7:0]  b;
    logic [3:0]  bif_inc;
    logic [2:0]  fix_pos, var_pos;
    logic [63:0] byte_wide;
    logic [63:0] fix_acc, var_acc;
    logic [3:0]  fix_n;
    logic        fix_done;
    logic        var_first, var_done, oversize, val_nz;
    logic [63:0] var_val, var_shift;
    logic [3:0]  var_bif;
    logic        done;
    vtp_rsp_t    out;

    always_comb begin
        b         = req.in_byte;
        bif_inc   = bif_reg + 4'd1;
        fix_pos   = bif_reg[2:0];
        var_pos   = bif_reg[2:0] - 3'd1;
        byte_wide = {56'd0, b};
        fix_acc   = ((bif_reg == 4'd0) ? 64'd0 : shift_reg) | (byte_wide << {fix_pos, 3'b000});
        var_acc   = shift_reg | (byte_wide << {var_pos, 3'b000});
        fix_n     = (phase_reg == PH_OUT_AMOUNT) ? 4'd8 : 4'd4;
        fix_done  = (bif_inc >= fix_n);
        var_first = (bif_reg == 4'd0);
        var_done  = var_first ? (b < VARINT_16) : (bif_inc > vwidth_reg);
        var_val   = var_first ? byte_wide : var_acc;
        var_shift = (var_first && !var_done) ? 64'd0 : var_val;
        var_bif   = var_done ? 4'd0 : (var_first ? 4'd1 : bif_inc);
        oversize  = |(var_val >> CNT_W);
        val_nz    = (var_val != 64'd0);
    end

    always_comb begin
        phase_next   = phase_reg;
        bif_next     = bif_reg;
        shift_next   = shift_reg;
        vwidth_next  = vwidth_reg;
        items_next   = items_reg;
        counter_next = counter_reg;
        script_next  = script_reg;
        err_next     = err_reg;
        done         = 1'b0;
        out.field_kind  = KIND_NONE;
        out.field_value = 64'd0;
        out.item_index  = 32'd0;
        out.status      = ST_RUNNING;

        if (phase_reg inside {[PH_IN_ID:PH_IN_SEQ], [PH_OUT_AMOUNT:PH_OUT_SCRIPT]}) begin
            out.item_index = 32'(counter_reg);
        end

        case (phase_reg)
            PH_VERSION, PH_IN_INDEX, PH_IN_SEQ, PH_OUT_AMOUNT, PH_LOCK: begin
                shift_next = fix_acc;
                bif_next   = fix_done ? 4'd0 : bif_inc;
                if (fix_done) begin
                    out.field_value = fix_acc;
                    case (phase_reg)
                        PH_VERSION: begin
                            out.field_kind = KIND_VERSION;
                            phase_next     = PH_IN_COUNT;
                        end
                        PH_IN_INDEX: begin
                            out.field_kind = KIND_INDEX;
                            phase_next     = PH_IN_SLEN;
                        end
                        PH_IN_SEQ: begin
                            out.field_kind = KIND_SEQUENCE;
                            counter_next   = counter_reg + 1'b1;
                            items_next     = items_reg - 1'b1;
                            if (items_reg == CNT_W'(1)) begin
                                phase_next = PH_OUT_COUNT;
                            end else begin
                                phase_next  = PH_IN_ID;
                                script_next = CNT_W'(ID_BYTES);
                            end
                        end
                        PH_OUT_AMOUNT: begin
                            out.field_kind = KIND_AMOUNT;
                            phase_next     = PH_OUT_SLEN;
                        end
                        default: begin
                            out.field_kind = KIND_LOCK_TIME;
                            done           = 1'b1;
                        end
                    endcase
                end
            end
            PH_IN_COUNT, PH_OUT_COUNT, PH_IN_SLEN, PH_OUT_SLEN: begin
                shift_next = var_shift;
                bif_next   = var_bif;
                if (var_first && !var_done) begin
                    vwidth_next = (b == VARINT_16) ? 4'd2 : (b == VARINT_32) ? 4'd4 : 4'd8;
                end
                if (var_done) begin
                    out.field_value = var_val;
                    case (phase_reg)
                        PH_IN_COUNT:  out.field_kind = KIND_IN_COUNT;
                        PH_OUT_COUNT: out.field_kind = KIND_OUT_COUNT;
                        PH_IN_SLEN:   out.field_kind = KIND_IN_SLEN;
                        default:      out.field_kind = KIND_OUT_SLEN;
                    endcase
                    if (oversize) begin
                        err_next   = ST_OVERSIZE;
                        phase_next = PH_DRAIN;
                    end else begin
                        case (phase_reg)
                            PH_IN_COUNT: begin
                                items_next   = var_val[CNT_W-1:0];
                                counter_next = '0;
                                if (val_nz) begin
                                    phase_next  = PH_IN_ID;
                                    script_next = CNT_W'(ID_BYTES);
                                end else begin
                                    phase_next = PH_OUT_COUNT;
                                end
                            end
                            PH_OUT_COUNT: begin
                                items_next   = var_val[CNT_W-1:0];
                                counter_next = '0;
                                phase_next   = val_nz ? PH_OUT_AMOUNT : PH_LOCK;
                            end
                            PH_IN_SLEN: begin
                                script_next = var_val[CNT_W-1:0];
                                phase_next  = val_nz ? PH_IN_SCRIPT : PH_IN_SEQ;
                            end
                            default: begin
                                script_next = var_val[CNT_W-1:0];
                                if (val_nz) begin
                                    phase_next = PH_OUT_SCRIPT;
                                end else begin
                                    counter_next = counter_reg + 1'b1;
                                    items_next   = items_reg - 1'b1;
                                    phase_next   = (items_reg == CNT_W'(1)) ? PH_LOCK
                                                                            : PH_OUT_AMOUNT;
                                end
                            end
                        endcase
                    end
                end
            end
            PH_IN_ID: begin
                out.field_kind  = KIND_ID_BYTE;
                out.field_value = byte_wide;
                script_next     = script_reg - 1'b1;
                if (script_reg == CNT_W'(1)) begin
                    phase_next = PH_IN_INDEX;
                end
            end
            PH_IN_SCRIPT: begin
                out.field_kind  = KIND_IN_SCRIPT;
                out.field_value = byte_wide;
                script_next     = script_reg - 1'b1;
                if (script_reg == CNT_W'(1)) begin
                    phase_next = PH_IN_SEQ;
                end
            end
            PH_OUT_SCRIPT: begin
                out.field_kind  = KIND_OUT_SCRIPT;
                out.field_value = byte_wide;
                script_next     = script_reg - 1'b1;
                if (script_reg == CNT_W'(1)) begin
                    counter_next = counter_reg + 1'b1;
                    items_next   = items_reg - 1'b1;
                    phase_next   = (items_reg == CNT_W'(1)) ? PH_LOCK : PH_OUT_AMOUNT;
                end
            end
            default: begin
            end
        endcase

        if (req.in_last) begin
            if (done) begin
                out.status = ST_OK;
            end else if (err_next != ST_RUNNING) begin
                out.status = err_next;
            end else begin
                out.status = ST_TRUNCATED;
            end
            phase_next   = PH_VERSION;
            bif_next     = 4'd0;
            shift_next   = 64'd0;
            vwidth_next  = 4'd0;
            items_next   = '0;
            counter_next = '0;
            script_next  = '0;
            err_next     = ST_RUNNING;
        end else if (done) begin
            err_next   = ST_TRAILING;
            phase_next = PH_DRAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_VERSION;
            bif_reg     <= 4'd0;
            shift_reg   <= 64'd0;
            vwidth_reg  <= 4'd0;
            items_reg   <= '0;
            counter_reg <= '0;
            script_reg  <= '0;
            err_reg     <= ST_RUNNING;
        end else if (ctl.valid && ctl.advance) begin
            phase_reg   <= phase_next;
            bif_reg     <= bif_next;
            shift_reg   <= shift_next;
            vwidth_reg  <= vwidth_next;
            items_reg   <= items_next;
            counter_reg <= counter_next;
            script_reg  <= script_next;
            err_reg     <= err_next;
        end
    end

    assign rsp = out;

endmodule

// File: rtl/vtp_out_stage.sv
module vtp_out_stage
    import vtp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  vtp_rsp_t rsp,
    output logic     free,
    output logic     m_valid,
    input  logic     m_ready,
    output vtp_rsp_t m_rsp
);

    logic     valid_reg;
    logic     valid_next;
    vtp_rsp_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= rsp;
        end
    end

    assign m_valid = valid_reg;
    assign m_rsp   = data_reg;

endmodule
